>>> sv/arw_pkg.sv
// Shared constants and types for the anti-replay window block.
package arw_pkg;

	localparam int CNT_W     = 32;
	localparam int WIN_BITS  = 1024;
	localparam int WORD_W    = 32;
	localparam int BIT_W     = $clog2(WORD_W);
	localparam int WIN_WORDS = WIN_BITS / WORD_W;
	localparam int WORD_AW   = $clog2(WIN_WORDS);
	localparam int WIN_LOG   = $clog2(WIN_BITS);
	localparam int WIDX_W    = CNT_W - BIT_W;
	localparam int KIND_W    = 2;

	typedef logic [KIND_W-1:0] kind_t;

	localparam kind_t KIND_CHECK  = 2'd0;
	localparam kind_t KIND_RECORD = 2'd1;
	localparam kind_t KIND_EPOCH  = 2'd2;

	// per-item plan for the word loop: bits to clear and the bit to set
	typedef struct packed {
		logic              active;
		logic [WIDX_W-1:0] lo_word;
		logic [BIT_W-1:0]  lo_bit;
		logic [WIDX_W-1:0] hi_word;
		logic [BIT_W-1:0]  hi_bit;
		logic              set_en;
		logic [WIDX_W-1:0] set_word;
		logic [BIT_W-1:0]  set_bit;
	} span_t;

endpackage

>>> sv/arw_ram.sv
// Generic single-write, single-read RAM with registered read data.
module arw_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 32,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             wr_en,
	input  logic [AW-1:0]    wr_addr,
	input  logic [WIDTH-1:0] wr_data,
	input  logic [AW-1:0]    rd_addr,
	output logic [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

>>> sv/arw_word_unit.sv
// Word update unit: clears the skipped range within one bitmap word and sets the item's bit.
module arw_word_unit (
	input  arw_pkg::span_t              span,
	input  logic [arw_pkg::WIDX_W-1:0]  widx,
	input  logic [arw_pkg::WORD_W-1:0]  old_word,
	output logic [arw_pkg::WORD_W-1:0]  new_word,
	output logic                        hit
);
	import arw_pkg::*;

	logic              in_lo;
	logic              in_hi;
	logic [BIT_W-1:0]  lb;
	logic [BIT_W-1:0]  hb;
	logic [WORD_W-1:0] clr;
	logic [WORD_W-1:0] set;

	always_comb begin
		in_lo = (widx >= span.lo_word);
		in_hi = (widx <= span.hi_word);
		lb    = (widx == span.lo_word) ? span.lo_bit : '0;
		hb    = (widx == span.hi_word) ? span.hi_bit : BIT_W'(WORD_W - 1);
		clr   = '0;
		if (span.active && in_lo && in_hi) begin
			clr = ({WORD_W{1'b1}} << lb) & ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hb));
		end
		set = '0;
		if (span.set_en && (widx == span.set_word)) begin
			set = WORD_W'(1) << span.set_bit;
		end
		new_word = (old_word & ~clr) | set;
		hit      = old_word[span.set_bit];
	end

endmodule

>>> sv/anti_replay_window.sv
// Anti-replay window top level: sequencer, highest counter, word valid flags, bitmap RAM.
// An accepted item passes the prep step, the word loop over n bitmap words (1..WIN_WORDS+1), a wait and a done step.
// A new item is taken only once the last result is raised; the done step holds while an unread result is pending.
// The word loop does one read-modify-write of a bitmap word per cycle.
// Reset: asynchronous, active low; an init state sets bit zero of word zero, then ready rises.
module anti_replay_window (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic [arw_pkg::KIND_W-1:0] kind,
	input  logic [arw_pkg::CNT_W-1:0]  counter,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       accepted
);
	import arw_pkg::*;

	typedef enum logic [5:0] {
		ST_INIT = 6'b000001,
		ST_IDLE = 6'b000010,
		ST_PREP = 6'b000100,
		ST_LOOP = 6'b001000,
		ST_WAIT = 6'b010000,
		ST_DONE = 6'b100000
	} state_t;

	state_t st_q;

	// control state
	logic [CNT_W-1:0]     highest_q;
	logic [WIN_WORDS-1:0] valid_q;     // word holds RAM data; clear words read as zero
	logic                 s1_vld_q;
	logic                 out_valid_q;

	// item payload and loop registers
	kind_t              kind_q;
	logic [CNT_W-1:0]   cnt_q;
	span_t              span_q;
	logic               gt_q;
	logic               old_q;
	logic               wen_q;
	logic [WIDX_W-1:0]  w_q;
	logic [WIDX_W-1:0]  w_s1;
	logic               last_s1;
	logic               res_q;
	logic               accepted_q;

	// prep arithmetic
	logic [CNT_W:0]     diff;
	logic [CNT_W-1:0]   back;
	logic [CNT_W-1:0]   lo;
	logic [CNT_W-1:0]   hi;
	logic               gt;
	logic               big;
	logic               too_old;
	logic               is_rec;
	logic               is_epoch;
	logic               clear_all;
	span_t              span_d;

	// RAM and word unit
	logic               ram_we;
	logic [WORD_AW-1:0] ram_waddr;
	logic [WORD_W-1:0]  ram_wdata;
	logic [WORD_W-1:0]  ram_rdata;
	logic [WORD_AW-1:0] s1_addr;
	logic [WORD_W-1:0]  old_word;
	logic [WORD_W-1:0]  new_word;
	logic               hit;
	logic               ok;
	logic               out_free;

	assign in_ready  = (st_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign accepted  = accepted_q;
	assign out_free  = !out_valid_q || out_ready;

	// window bookkeeping: diff > 0 means a newer counter
	always_comb begin
		diff      = {1'b0, cnt_q} - {1'b0, highest_q};
		back      = highest_q - cnt_q;
		gt        = !diff[CNT_W] && (diff[CNT_W-1:0] != '0);
		big       = |diff[CNT_W-1:WIN_LOG];
		too_old   = |back[CNT_W-1:WIN_LOG];
		lo        = highest_q + CNT_W'(1);
		hi        = cnt_q - CNT_W'(1);
		is_rec    = (kind_q == KIND_RECORD);
		is_epoch  = (kind_q == KIND_EPOCH);
		clear_all = is_epoch || (is_rec && gt && big);

		span_d.active   = is_rec && gt && !big;
		span_d.lo_word  = lo[CNT_W-1:BIT_W];
		span_d.lo_bit   = lo[BIT_W-1:0];
		span_d.hi_word  = hi[CNT_W-1:BIT_W];
		span_d.hi_bit   = hi[BIT_W-1:0];
		span_d.set_en   = is_rec || is_epoch;
		span_d.set_word = cnt_q[CNT_W-1:BIT_W];
		span_d.set_bit  = cnt_q[BIT_W-1:0];
	end

	assign s1_addr  = w_s1[WORD_AW-1:0];
	assign old_word = valid_q[s1_addr] ? ram_rdata : '0;
	assign ok       = (kind_q == KIND_EPOCH) || gt_q || (!old_q && !hit);

	arw_word_unit u_word (
		.span     (span_q),
		.widx     (w_s1),
		.old_word (old_word),
		.new_word (new_word),
		.hit      (hit)
	);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = s1_addr;
		ram_wdata = new_word;
		if (st_q == ST_INIT) begin
			ram_we    = 1'b1;
			ram_waddr = '0;
			ram_wdata = WORD_W'(1);
		end else if (s1_vld_q && wen_q) begin
			ram_we = 1'b1;
		end
	end

	arw_ram #(
		.WIDTH (WORD_W),
		.DEPTH (WIN_WORDS)
	) u_ram (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (w_q[WORD_AW-1:0]),
		.rd_data (ram_rdata)
	);

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_INIT;
			highest_q   <= '0;
			valid_q     <= '0;
			s1_vld_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			s1_vld_q <= (st_q == ST_LOOP);
			if (s1_vld_q && wen_q) begin
				valid_q[s1_addr] <= 1'b1;
			end
			case (st_q)
				ST_INIT: begin
					valid_q[0] <= 1'b1;
					st_q       <= ST_IDLE;
				end
				ST_IDLE: begin
					if (in_valid) begin
						st_q <= ST_PREP;
					end
				end
				ST_PREP: begin
					// whole-bitmap clear by dropping the word flags
					if (clear_all) begin
						valid_q <= '0;
					end
					if (is_epoch || (is_rec && gt)) begin
						highest_q <= cnt_q;
					end
					st_q <= ST_LOOP;
				end
				ST_LOOP: begin
					if (w_q == span_q.set_word) begin
						st_q <= ST_WAIT;
					end
				end
				ST_WAIT: begin
					st_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						st_q        <= ST_IDLE;
					end
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item payload, loop index and the word stage
	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_q <= kind;
			cnt_q  <= counter;
		end
		if (st_q == ST_PREP) begin
			span_q <= span_d;
			gt_q   <= gt;
			old_q  <= too_old;
			wen_q  <= is_rec || is_epoch;
			// start at the first skipped word, or straight at the item's word
			w_q    <= span_d.active ? span_d.lo_word : span_d.set_word;
		end
		if (st_q == ST_LOOP) begin
			w_s1    <= w_q;
			last_s1 <= (w_q == span_q.set_word);
			if (w_q != span_q.set_word) begin
				w_q <= w_q + WIDX_W'(1);
			end
		end
		if (s1_vld_q && last_s1) begin
			res_q <= ok;
		end
		if ((st_q == ST_DONE) && out_free) begin
			accepted_q <= res_q;
		end
	end

	// the final word of an item is processed only in the wait step
	assert property (@(posedge clk) disable iff (!arst_n)
		(s1_vld_q && last_s1) |-> (st_q == ST_WAIT))
		else $error("last word stage outside wait step");

	// an epoch start always reports fresh
	assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_WAIT) && (kind_q == KIND_EPOCH)) |=> res_q)
		else $error("epoch start not accepted");

	// only an epoch start may move the highest counter back
	assert property (@(posedge clk) disable iff (!arst_n)
		((st_q == ST_PREP) && (kind_q != KIND_EPOCH)) |=> (highest_q >= $past(highest_q)))
		else $error("highest counter moved back");

	// a result is raised only from the done step, once the loop has finished
	assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(st_q) == ST_DONE))
		else $error("result raised outside done step");

endmodule
